@@ sv/dfr_pkg.sv @@
// dfr_pkg: shared types and constants of the delimited frame receiver
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package dfr_pkg;

  // framing bytes and checksum seed
  localparam logic [7:0] START_BYTE = 8'h7B;
  localparam logic [7:0] END_BYTE   = 8'h7D;
  localparam logic [7:0] XOR_SEED   = 8'h55;

  // frame layout after the start byte: six payload bytes, check byte, end byte
  localparam int PAYLOAD_LEN = 6;
  localparam int POS_W       = 3;
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(PAYLOAD_LEN);
  localparam logic [POS_W-1:0] END_POS   = POS_W'(PAYLOAD_LEN + 1);

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PAYLOAD,
    KIND_CHECK,
    KIND_END
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_END   = 2'd1,
    STATUS_BAD_CHECK = 2'd2
  } status_t;

  // one classified byte as it travels through the queue
  typedef struct packed {
    kind_t             kind;
    logic [POS_W-1:0]  pos;
    logic [7:0]        data;
  } beat_t;

  // result beat, word_zero in the lowest bits, padded to 56 bits
  typedef struct packed {
    logic [5:0]  pad;
    status_t     frame_status;
    logic [15:0] word_two;
    logic [15:0] word_one;
    logic [15:0] word_zero;
  } result_t;

  // queue handshake between front, queue and back
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

`default_nettype wire

@@ sv/dfr_front.sv @@
// dfr_front: takes input bytes, tracks frame position, classifies frame bytes
// depends on dfr_pkg
`default_nettype none

module dfr_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,
  input  wire dfr_pkg::q_stat_t    q_stat,
  output logic                     push,
  output dfr_pkg::beat_t           push_beat
);

  logic                      in_frame;
  logic [dfr_pkg::POS_W-1:0] pos;
  logic                      accept;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && !q_stat.full;
  assign push     = accept && in_frame;

  always_comb begin
    push_beat.data = s_tdata;
    push_beat.pos  = pos;
    if (pos == dfr_pkg::END_POS) begin
      push_beat.kind = dfr_pkg::KIND_END;
    end else if (pos == dfr_pkg::CHECK_POS) begin
      push_beat.kind = dfr_pkg::KIND_CHECK;
    end else begin
      push_beat.kind = dfr_pkg::KIND_PAYLOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      pos      <= '0;
    end else if (accept) begin
      if (!in_frame) begin
        // idle: only the start byte opens a frame
        if (s_tdata == dfr_pkg::START_BYTE) begin
          in_frame <= 1'b1;
          pos      <= '0;
        end
      end else if (pos == dfr_pkg::END_POS) begin
        in_frame <= 1'b0;
        pos      <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/dfr_queue.sv @@
// dfr_queue: short flop queue of classified beats between front and back
// depends on dfr_pkg
`default_nettype none

module dfr_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dfr_pkg::q_ctrl_t  q_ctrl,
  input  wire dfr_pkg::beat_t    push_beat,
  output dfr_pkg::q_stat_t       q_stat,
  output dfr_pkg::beat_t         head
);

  dfr_pkg::beat_t             entries [dfr_pkg::QDEPTH];
  logic [dfr_pkg::QPTR_W-1:0] wr_ptr;
  logic [dfr_pkg::QPTR_W-1:0] rd_ptr;
  logic [dfr_pkg::QCNT_W-1:0] count;

  assign q_stat.full  = (count == dfr_pkg::QCNT_W'(dfr_pkg::QDEPTH));
  assign q_stat.valid = (count != '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_ctrl.push) begin
      entries[wr_ptr] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_ctrl.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_ctrl.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({q_ctrl.push, q_ctrl.pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full && !q_ctrl.pop |-> !q_ctrl.push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_ctrl.pop |-> q_stat.valid)
    else $error("queue read while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dfr_pkg::QCNT_W'(dfr_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    q_ctrl.push && !q_ctrl.pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow a lone write");

endmodule

`default_nettype wire

@@ sv/dfr_back.sv @@
// dfr_back: collects payload and check bytes, checks the frame, holds the result beat
// depends on dfr_pkg
`default_nettype none

module dfr_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dfr_pkg::q_stat_t  q_stat,
  input  wire dfr_pkg::beat_t    head,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output dfr_pkg::result_t       result
);

  logic [7:0]       payload [dfr_pkg::PAYLOAD_LEN];
  logic [7:0]       running_xor;
  logic [7:0]       received_check;
  logic             out_free;
  logic             load;
  dfr_pkg::status_t status;

  assign out_free = !m_tvalid || m_tready;
  assign pop      = q_stat.valid && ((head.kind != dfr_pkg::KIND_END) || out_free);
  assign load     = pop && (head.kind == dfr_pkg::KIND_END);

  // a bad end byte wins over a bad checksum
  always_comb begin
    if (head.data != dfr_pkg::END_BYTE) begin
      status = dfr_pkg::STATUS_BAD_END;
    end else if (running_xor != received_check) begin
      status = dfr_pkg::STATUS_BAD_CHECK;
    end else begin
      status = dfr_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head.kind)
        dfr_pkg::KIND_PAYLOAD: begin
          payload[head.pos] <= head.data;
        end
        dfr_pkg::KIND_CHECK: begin
          received_check <= head.data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor <= dfr_pkg::XOR_SEED;
    end else if (pop && head.kind == dfr_pkg::KIND_PAYLOAD) begin
      if (head.pos == '0) begin
        running_xor <= dfr_pkg::XOR_SEED ^ head.data;
      end else begin
        running_xor <= running_xor ^ head.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.pad          <= '0;
      result.frame_status <= status;
      if (status == dfr_pkg::STATUS_OK) begin
        result.word_zero <= {payload[1], payload[0]};
        result.word_one  <= {payload[3], payload[2]};
        result.word_two  <= {payload[5], payload[4]};
      end else begin
        result.word_zero <= '0;
        result.word_one  <= '0;
        result.word_two  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !load)
    else $error("held result overwritten");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> result.frame_status != 2'd3)
    else $error("undefined frame status");

  a_error_words: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result.frame_status != dfr_pkg::STATUS_OK |->
      result.word_zero == '0 && result.word_one == '0 && result.word_two == '0)
    else $error("words not cleared on a bad frame");

endmodule

`default_nettype wire

@@ sv/delimited_frame_receiver_top.sv @@
// delimited_frame_receiver_top: start/end delimited frame receiver with xor checksum
// depends on dfr_pkg, dfr_front, dfr_queue, dfr_back
//
//   channel  dir  ports                          payload
//   -------  ---  -----------------------------  -------------------------------------
//   input    in   s_tvalid s_tready s_tdata[7:0]  rx_byte
//   result   out  m_tvalid m_tready m_tdata[55:0] word_zero, word_one, word_two,
//                                                frame_status, zero pad
//
// one byte is taken per cycle while s_tready is high; the front classifies it
// in the cycle it is taken, and a frame byte reaches the back through the
// registered entries of a four-beat queue; the result beat is loaded at the
// edge the end byte leaves the queue, and m_tvalid is registered with it
// rst is synchronous, active high; it drops any partial frame and empties the queue
// a stalled result holds the end byte and all beats behind it; s_tready falls when full
`default_nettype none

module delimited_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata    // [15:0] word_zero, [31:16] word_one,
                                      // [47:32] word_two, [49:48] frame_status, [55:50] zero
);

  dfr_pkg::q_ctrl_t q_ctrl;
  dfr_pkg::q_stat_t q_stat;
  dfr_pkg::beat_t   push_beat;
  dfr_pkg::beat_t   head;
  dfr_pkg::result_t result;
  logic             push;
  logic             pop;

  // front: frame position tracking, start byte detection, byte classification
  dfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_beat (push_beat)
  );

  assign q_ctrl.push = push;
  assign q_ctrl.pop  = pop;

  // queue decouples input acceptance from result stalls
  dfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_ctrl    (q_ctrl),
    .push_beat (push_beat),
    .q_stat    (q_stat),
    .head      (head)
  );

  // back: payload store, running xor, frame check and result register
  dfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_stat   (q_stat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .result   (result)
  );

  assign m_tdata = result;

endmodule

`default_nettype wire
